[rtl/core/mcpt_pkg.sv]
// Shared constants, command codes and control structs of the periodic timer block.
package mcpt_pkg;

  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned FIFO_DEPTH = 8;

  localparam int unsigned SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_CREATE_FLAG = 3'd1,
    CMD_CREATE_QUE  = 3'd2,
    CMD_START       = 3'd3,
    CMD_STOP        = 3'd4,
    CMD_SET_PERIOD  = 3'd5,
    CMD_DISPATCH    = 3'd6,
    CMD_CLEAR_STATS = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_QUEUED = 2'd2,
    KIND_FLAG   = 2'd3
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic tick_step;
    logic drain_step;
    logic flag_step;
    logic emit_done;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic fifo_empty;
    logic idx_last;
  } dp_status_t;

endpackage

[rtl/core/mcpt_ctrl.sv]
// Sequencing state machine of the periodic timer block.
module mcpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          in_cmd_i,
  output logic                in_ready_o,
  input  mcpt_pkg::dp_status_t status_i,
  output mcpt_pkg::dp_cmd_t   cmd_o
);
  import mcpt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_TICK  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_FLAG  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (cmd_e'(in_cmd_i))
            CMD_TICK:     state_d = S_TICK;
            CMD_DISPATCH: state_d = S_DRAIN;
            default:      state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (status_i.idx_last) state_d = S_DONE;
      end
      S_DRAIN: begin
        if (status_i.fifo_empty) begin
          state_d = S_FLAG;
        end else if (status_i.out_free) begin
          cmd_o.drain_step = 1'b1;
        end
      end
      S_FLAG: begin
        if (status_i.out_free) begin
          cmd_o.flag_step = 1'b1;
          if (status_i.idx_last) state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/mcpt_datapath.sv]
// Slot table, event FIFO, statistics and output beat register.
module mcpt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          in_cmd_i,
  input  logic [3:0]          in_slot_id_i,
  input  logic [15:0]         in_period_i,
  input  logic                in_handler_valid_i,
  input  mcpt_pkg::dp_cmd_t   cmd_i,
  output mcpt_pkg::dp_status_t status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          out_kind_o,
  output logic [3:0]          out_timer_o,
  output logic                out_ok_o,
  output logic [3:0]          out_qused_o,
  output logic [3:0]          out_qpeak_o,
  output logic [15:0]         out_ovf_o,
  output logic [31:0]         out_ticks_o,
  output logic                out_last_o
);
  import mcpt_pkg::*;

  // Captured item
  logic [2:0]  op_q;
  logic [3:0]  id_q;
  logic [15:0] per_q;
  logic        hv_q;

  // Slot table
  logic [NUM_SLOTS-1:0] used_q, flag_q, active_q, pend_q;
  logic [15:0]          period_q [NUM_SLOTS];
  logic [15:0]          cnt_q    [NUM_SLOTS];

  // Event FIFO and stats
  logic [SLOT_W-1:0]  fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   head_q, tail_q;
  logic [COUNT_W-1:0] fcount_q, fpeak_q;
  logic [15:0]        drop_q;
  logic [31:0]        ticks_q;
  logic [SLOT_W-1:0]  idx_q;

  // Output beat register
  logic        ovalid_q;
  logic [1:0]  okind_q;
  logic [3:0]  otimer_q;
  logic        ook_q;
  logic [3:0]  oqused_q, oqpeak_q;
  logic [15:0] oovf_q;
  logic [31:0] oticks_q;
  logic        olast_q;

  logic              out_free;
  logic [15:0]       cur_cnt, inc_cnt;
  logic              slot_run, fire, fifo_full;
  logic [SLOT_W-1:0] head_id, free_idx, cid;
  logic              free_found, id_ok, flag_hit;

  assign out_free = !ovalid_q || out_ready_i;
  assign status_o.out_free   = out_free;
  assign status_o.fifo_empty = (fcount_q == '0);
  assign status_o.idx_last   = (idx_q == SLOT_W'(NUM_SLOTS - 1));

  // Tick arithmetic for the walked slot
  assign cur_cnt   = cnt_q[idx_q];
  assign inc_cnt   = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + 16'd1;
  assign slot_run  = used_q[idx_q] && active_q[idx_q];
  assign fire      = slot_run && (inc_cnt >= period_q[idx_q]);
  assign fifo_full = (fcount_q == COUNT_W'(FIFO_DEPTH));
  assign head_id   = fifo_mem[head_q];
  assign flag_hit  = flag_q[idx_q] && active_q[idx_q] && used_q[idx_q] && pend_q[idx_q];
  assign id_ok     = ({1'b0, id_q} < 5'(NUM_SLOTS));
  assign cid       = SLOT_W'(id_q);

  // Find first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_cmd_i;
      id_q  <= in_slot_id_i;
      per_q <= in_period_i;
      hv_q  <= in_handler_valid_i;
    end
  end

  // Write FIFO entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_step && fire && !flag_q[idx_q] && !fifo_full) begin
      fifo_mem[tail_q] <= idx_q;
    end
  end

  // Update slot table, FIFO pointers and stats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      flag_q   <= '0;
      active_q <= '0;
      pend_q   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
      head_q   <= '0;
      tail_q   <= '0;
      fcount_q <= '0;
      fpeak_q  <= '0;
      drop_q   <= '0;
      ticks_q  <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.capture) idx_q <= '0;
      if (cmd_i.tick_step || cmd_i.flag_step) idx_q <= idx_q + SLOT_W'(1);

      // Advance one slot of a tick
      if (cmd_i.tick_step) begin
        if (slot_run) cnt_q[idx_q] <= fire ? 16'd0 : inc_cnt;
        if (fire && flag_q[idx_q]) begin
          pend_q[idx_q] <= 1'b1;
        end else if (fire && !fifo_full) begin
          tail_q   <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
          fcount_q <= fcount_q + COUNT_W'(1);
          if (fcount_q + COUNT_W'(1) > fpeak_q) fpeak_q <= fcount_q + COUNT_W'(1);
        end else if (fire && drop_q != CountMax) begin
          drop_q <= drop_q + 16'd1;
        end
        if (status_o.idx_last) ticks_q <= ticks_q + 32'd1;
      end

      // Pop one FIFO entry
      if (cmd_i.drain_step) begin
        head_q   <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
        fcount_q <= fcount_q - COUNT_W'(1);
      end

      // Clear a reported flag
      if (cmd_i.flag_step && flag_hit) pend_q[idx_q] <= 1'b0;

      // Single-beat commands
      if (cmd_i.exec) begin
        case (cmd_e'(op_q))
          CMD_CREATE_FLAG, CMD_CREATE_QUE: begin
            if (free_found) begin
              period_q[free_idx] <= per_q;
              cnt_q[free_idx]    <= '0;
              active_q[free_idx] <= 1'b0;
              flag_q[free_idx]   <= (cmd_e'(op_q) == CMD_CREATE_FLAG);
              pend_q[free_idx]   <= 1'b0;
              used_q[free_idx]   <= hv_q;
            end
          end
          CMD_START: begin
            if (id_ok && used_q[cid]) begin
              cnt_q[cid]    <= '0;
              pend_q[cid]   <= 1'b0;
              active_q[cid] <= 1'b1;
            end
          end
          CMD_STOP: begin
            if (id_ok) begin
              active_q[cid] <= 1'b0;
              pend_q[cid]   <= 1'b0;
            end
          end
          CMD_SET_PERIOD: begin
            if (id_ok) period_q[cid] <= per_q;
          end
          CMD_CLEAR_STATS: begin
            fpeak_q <= fcount_q;
            drop_q  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Load or drain the output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if ((cmd_i.drain_step && used_q[head_id]) || (cmd_i.flag_step && flag_hit) ||
                 cmd_i.exec || cmd_i.emit_done) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      okind_q  <= KIND_DONE;
      otimer_q <= '0;
      ook_q    <= 1'b0;
      oqused_q <= 4'(fcount_q);
      oqpeak_q <= 4'(fpeak_q);
      oovf_q   <= drop_q;
      oticks_q <= ticks_q;
      olast_q  <= cmd_i.exec || cmd_i.emit_done;
      if (cmd_i.drain_step) begin
        okind_q  <= KIND_QUEUED;
        otimer_q <= 4'(head_id);
        oqused_q <= '0;
      end else if (cmd_i.flag_step) begin
        okind_q  <= KIND_FLAG;
        otimer_q <= 4'(idx_q);
      end else if (cmd_i.exec) begin
        if (cmd_e'(op_q) == CMD_CREATE_FLAG || cmd_e'(op_q) == CMD_CREATE_QUE) begin
          okind_q <= KIND_CREATE;
          if (free_found) begin
            otimer_q <= 4'(free_idx);
            ook_q    <= 1'b1;
          end
        end else if (cmd_e'(op_q) == CMD_CLEAR_STATS) begin
          oqpeak_q <= 4'(fcount_q);
          oovf_q   <= '0;
        end
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_timer_o = otimer_q;
  assign out_ok_o    = ook_q;
  assign out_qused_o = oqused_q;
  assign out_qpeak_o = oqpeak_q;
  assign out_ovf_o   = oovf_q;
  assign out_ticks_o = oticks_q;
  assign out_last_o  = olast_q;

endmodule

[rtl/core/multi_channel_periodic_timer_events_top.sv]
// Top level of the multi-channel periodic timer with event FIFO.
// One command beat is taken at a time and answered by one or more result beats, the
// final one marked by tlast; the command code rides on s_axis_tuser and the result kind
// on m_axis_tuser. A tick walks the slot table one slot per cycle; dispatch pops one
// FIFO entry per cycle, then checks one slot per cycle for pending flags, each of its
// steps only while the result side can take a beat. Queued ids and pending flags are
// reported with the statistics as they stand after the whole command.
module multi_channel_periodic_timer_events_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot_id[3:0], period[19:4], handler_valid[20], zero[23:21]
  input  logic [mcpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [2:0]                         s_axis_tuser,  // cmd[2:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // event_timer[3:0], create_ok[4], queue_used[8:5], queue_peak[12:9],
  // overflow_count[28:13], tick_total[60:29], zero[63:61]
  output logic [mcpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // result_kind[1:0]
  output logic                               m_axis_tlast
);
  import mcpt_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  logic [1:0]  kind;
  logic [3:0]  timer, qused, qpeak;
  logic        ok;
  logic [15:0] ovf;
  logic [31:0] ticks;

  mcpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  mcpt_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_cmd_i           (s_axis_tuser),
    .in_slot_id_i       (s_axis_tdata[3:0]),
    .in_period_i        (s_axis_tdata[19:4]),
    .in_handler_valid_i (s_axis_tdata[20]),
    .cmd_i              (dp_cmd),
    .status_o           (dp_status),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_kind_o         (kind),
    .out_timer_o        (timer),
    .out_ok_o           (ok),
    .out_qused_o        (qused),
    .out_qpeak_o        (qpeak),
    .out_ovf_o          (ovf),
    .out_ticks_o        (ticks),
    .out_last_o         (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tdata = {3'b000, ticks, ovf, qpeak, qused, ok, timer};
  assign m_axis_tuser = kind;

endmodule

[verif/multi_channel_periodic_timer_events_top_tb.sv]
// Testbench for the periodic timer block: directed table, random commands, self-checking.
module multi_channel_periodic_timer_events_top_tb;
  import mcpt_pkg::*;

  typedef struct packed {
    logic        last;
    logic [31:0] tick_total;
    logic [15:0] overflow_count;
    logic [3:0]  queue_peak;
    logic [3:0]  queue_used;
    logic        create_ok;
    logic [3:0]  event_timer;
    kind_e       kind;
  } evt_t;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  id;
    logic [15:0] period;
    logic        hv;
    logic        fixed;
    evt_t        want;
  } row_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  multi_channel_periodic_timer_events_top dut (.*);

  // Timer table mirror
  logic        t_used [NUM_SLOTS];
  logic        t_flag [NUM_SLOTS];
  logic        t_act  [NUM_SLOTS];
  logic        t_pend [NUM_SLOTS];
  logic [15:0] t_per  [NUM_SLOTS];
  logic [15:0] t_cnt  [NUM_SLOTS];
  logic [2:0]  ev_fifo[$];
  logic [3:0]  fifo_peak;
  logic [15:0] drops;
  logic [31:0] ticks;

  evt_t pending_events[$];
  int   err_cnt;
  int   idle_in, idle_out;
  row_t dir_rows[$];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %h exp %h at %0t", what, got, exp, $time);
    err_cnt++;
  endtask

  function automatic evt_t mk(kind_e k, logic [3:0] id, logic ok);
    evt_t e;
    e = '0;
    e.kind = k;
    e.event_timer = id;
    e.create_ok = ok;
    return e;
  endfunction

  // Compute the result beats of one command and advance the table mirror
  task automatic predict_timer_cmd(cmd_e cmd, logic [3:0] id, logic [15:0] per, logic hv);
    evt_t outs[$];
    int   slot;
    logic [2:0] q;
    slot = -1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (t_used[i] && t_act[i]) begin
            if (t_cnt[i] != CountMax) t_cnt[i]++;
            if (t_cnt[i] >= t_per[i]) begin
              t_cnt[i] = 0;
              if (t_flag[i]) t_pend[i] = 1;
              else if (ev_fifo.size() < FIFO_DEPTH) begin
                ev_fifo.push_back(i[2:0]);
                if (ev_fifo.size() > fifo_peak) fifo_peak = 4'(ev_fifo.size());
              end else if (drops != CountMax) drops++;
            end
          end
        end
        ticks++;
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
      CMD_CREATE_FLAG, CMD_CREATE_QUE: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!t_used[i]) slot = i;
        if (slot >= 0) begin
          t_per[slot] = per;
          t_cnt[slot] = 0;
          t_act[slot] = 0;
          t_flag[slot] = (cmd == CMD_CREATE_FLAG);
          t_pend[slot] = 0;
          t_used[slot] = hv;
          outs.push_back(mk(KIND_CREATE, slot[3:0], 1));
        end else outs.push_back(mk(KIND_CREATE, 0, 0));
      end
      CMD_START: begin
        if (id < NUM_SLOTS && t_used[id]) begin
          t_cnt[id] = 0;
          t_pend[id] = 0;
          t_act[id] = 1;
        end
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
      CMD_STOP: begin
        if (id < NUM_SLOTS) begin
          t_act[id] = 0;
          t_pend[id] = 0;
        end
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
      CMD_SET_PERIOD: begin
        if (id < NUM_SLOTS) t_per[id] = per;
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
      CMD_DISPATCH: begin
        while (ev_fifo.size() > 0) begin
          q = ev_fifo.pop_front();
          if (t_used[q]) outs.push_back(mk(KIND_QUEUED, {1'b0, q}, 0));
        end
        for (int i = 0; i < NUM_SLOTS; i++)
          if (t_flag[i] && t_act[i] && t_used[i] && t_pend[i]) begin
            t_pend[i] = 0;
            outs.push_back(mk(KIND_FLAG, i[3:0], 0));
          end
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
      default: begin
        fifo_peak = 4'(ev_fifo.size());
        drops = 0;
        outs.push_back(mk(KIND_DONE, 0, 0));
      end
    endcase
    // Stats are as they stand after the whole command
    foreach (outs[k]) begin
      outs[k].queue_used = 4'(ev_fifo.size());
      outs[k].queue_peak = fifo_peak;
      outs[k].overflow_count = drops;
      outs[k].tick_total = ticks;
      outs[k].last = (k == outs.size() - 1);
      pending_events.push_back(outs[k]);
    end
  endtask

  // Send one command beat, with random sender gaps; valid stays up until the next gap
  task automatic send_cmd(cmd_e cmd, logic [3:0] id, logic [15:0] per, logic hv);
    while (idle_in > 0 && $urandom_range(99) < idle_in) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, hv, per, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_timer_cmd(cmd, id, per, hv);
  endtask

  // Receiver: random stall, compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    evt_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = evt_t'({m_axis_tlast, m_axis_tdata[60:0], m_axis_tuser});
      if (pending_events.size() == 0) report("unexpected beat", got, 0);
      else begin
        exp = pending_events.pop_front();
        if (got.kind != exp.kind) report("result_kind", got.kind, exp.kind);
        if (got.event_timer != exp.event_timer) report("event_timer", got.event_timer, exp.event_timer);
        if (got.create_ok != exp.create_ok) report("create_ok", got.create_ok, exp.create_ok);
        if (got.queue_used != exp.queue_used) report("queue_used", got.queue_used, exp.queue_used);
        if (got.queue_peak != exp.queue_peak) report("queue_peak", got.queue_peak, exp.queue_peak);
        if (got.overflow_count != exp.overflow_count)
          report("overflow_count", got.overflow_count, exp.overflow_count);
        if (got.tick_total != exp.tick_total) report("tick_total", got.tick_total, exp.tick_total);
        if (got.last != exp.last) report("tlast", got.last, exp.last);
        if (m_axis_tdata[63:61] !== 3'b000) report("pad bits", m_axis_tdata[63:61], 0);
      end
    end
    m_axis_tready <= !(idle_out > 0 && $urandom_range(99) < idle_out);
  end

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic row_t drow(cmd_e c, logic [3:0] id, logic [15:0] p, logic hv,
                                logic fx, evt_t w);
    row_t r;
    r.cmd = c; r.id = id; r.period = p; r.hv = hv; r.fixed = fx; r.want = w;
    return r;
  endfunction

  // Random command mix, weighted toward ticks; start, stop and set period mostly use slot ids in range
  task automatic random_cmd();
    int          r;
    logic [3:0]  any_id, live_id;
    logic [15:0] any_per, cre_per, set_per;
    logic        any_hv, cre_hv;
    r       = $urandom_range(99);
    any_id  = 4'($urandom);
    live_id = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(7));
    any_per = 16'($urandom);
    cre_per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    set_per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    any_hv  = 1'($urandom);
    cre_hv  = ($urandom_range(5) != 0);
    if (r < 40) send_cmd(CMD_TICK, any_id, any_per, any_hv);
    else if (r < 50) send_cmd(CMD_DISPATCH, any_id, any_per, any_hv);
    else if (r < 58)
      send_cmd($urandom_range(1) ? CMD_CREATE_FLAG : CMD_CREATE_QUE, any_id, cre_per, cre_hv);
    else if (r < 72) send_cmd(CMD_START, live_id, any_per, any_hv);
    else if (r < 80) send_cmd(CMD_STOP, live_id, any_per, any_hv);
    else if (r < 90) send_cmd(CMD_SET_PERIOD, live_id, set_per, any_hv);
    else if (r < 94) send_cmd(CMD_CLEAR_STATS, any_id, any_per, any_hv);
    else begin
      // Free every slot by refilling the table from scratch is not possible; stop one instead
      send_cmd(CMD_STOP, 4'($urandom_range(7)), any_per, any_hv);
    end
  endtask

  initial begin
    evt_t w, got;
    int   phase_idle_in[4];
    int   phase_idle_out[4];
    phase_idle_in  = '{0, 88, 0, 16};
    phase_idle_out = '{0, 0, 88, 16};
    err_cnt = 0;
    idle_in = 0;
    idle_out = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      t_used[i] = 0; t_flag[i] = 0; t_act[i] = 0; t_pend[i] = 0; t_per[i] = 0; t_cnt[i] = 0;
    end
    fifo_peak = 0; drops = 0; ticks = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: fixed rows hold the beat read off by hand
    w = mk(KIND_DONE, 0, 0); w.tick_total = 1; w.last = 1;
    dir_rows.push_back(drow(CMD_TICK, 4'hF, 16'hFFFF, 1, 1, w));
    w = mk(KIND_DONE, 0, 0); w.tick_total = 1; w.last = 1;
    dir_rows.push_back(drow(CMD_DISPATCH, 0, 0, 0, 1, w));
    w = mk(KIND_CREATE, 0, 1); w.tick_total = 1; w.last = 1;
    dir_rows.push_back(drow(CMD_CREATE_QUE, 0, 16'h0000, 0, 1, w));  // no handler: slot stays free
    dir_rows.push_back(drow(CMD_CREATE_QUE, 0, 16'h0000, 1, 0, w));  // period zero queue slot
    dir_rows.push_back(drow(CMD_CREATE_FLAG, 0, 16'd2, 1, 0, w));
    dir_rows.push_back(drow(CMD_CREATE_FLAG, 0, 16'hFFFF, 1, 0, w));
    dir_rows.push_back(drow(CMD_START, 4'hF, 0, 0, 0, w));           // out of range id
    dir_rows.push_back(drow(CMD_START, 4'd7, 0, 0, 0, w));           // free slot
    dir_rows.push_back(drow(CMD_START, 4'd0, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_START, 4'd1, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_START, 4'd2, 0, 0, 0, w));
    for (int i = 0; i < 10; i++) dir_rows.push_back(drow(CMD_TICK, 0, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_DISPATCH, 0, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_SET_PERIOD, 4'd6, 16'hFFFF, 0, 0, w)); // free slot still written
    dir_rows.push_back(drow(CMD_STOP, 4'd9, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_CLEAR_STATS, 0, 0, 0, 0, w));
    dir_rows.push_back(drow(CMD_STOP, 4'd1, 0, 0, 0, w));

    foreach (dir_rows[r]) begin
      send_cmd(dir_rows[r].cmd, dir_rows[r].id, dir_rows[r].period, dir_rows[r].hv);
      if (dir_rows[r].fixed) begin
        // Hold the typed beat against what the predictor queued
        got = pending_events[pending_events.size() - 1];
        if (got != dir_rows[r].want) report("table row", got, dir_rows[r].want);
      end
    end
    // Fill the table so a full-table create is seen, then drain ticks into FIFO overflow
    for (int i = 0; i < 6; i++) send_cmd(CMD_CREATE_QUE, 0, 16'd0, 1);
    for (int i = 0; i < 8; i++) send_cmd(CMD_START, i[3:0], 0, 0);
    for (int i = 0; i < 3; i++) send_cmd(CMD_TICK, 0, 0, 0);
    send_cmd(CMD_DISPATCH, 0, 0, 0);
    wait_drained();  // sender holds off until every result is in

    // Random phases with different idling
    for (int p = 0; p < 5; p++) begin
      idle_in = phase_idle_in[p % 4];
      idle_out = phase_idle_out[p % 4];
      for (int n = 0; n < 37; n++) random_cmd();
    end
    idle_in = 0;
    idle_out = 0;
    send_cmd(CMD_DISPATCH, 0, 0, 0);
    wait_drained();

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
